// ----- sv/gma_pkg.sv -----
// shared types and constants for the gated moving average block
// no dependencies
package gma_pkg;

  localparam int WINDOW_SIZE = 8;
  localparam int RANGE_W     = 8;
  localparam int STATUS_W    = 4;
  localparam int THR_W       = 4;
  localparam int HELD_W      = 4;
  localparam int MEAN_W      = 16;
  localparam int FRAC_W      = 8;

  localparam int PTR_W    = $clog2(WINDOW_SIZE);
  localparam int CNT_W    = $clog2(WINDOW_SIZE + 1);
  localparam int SUM_W    = $clog2(((1 << RANGE_W) - 1) * WINDOW_SIZE + 1);
  localparam int DIVD_W   = SUM_W + FRAC_W;
  localparam int DIV_CNT_W = $clog2(MEAN_W);
  localparam int CMP_W    = (CNT_W > THR_W) ? CNT_W : THR_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [THR_W-1:0] READY_THR_RESET = THR_W'(5);
  localparam logic [STATUS_W-1:0] STATUS_OK    = '0;

  typedef struct packed {
    logic [STATUS_W-1:0] measure_status;
    logic [RANGE_W-1:0]  measured_range;
  } gma_in_t;

  typedef struct packed {
    logic [MEAN_W-1:0]   filtered_distance;
    logic                is_ready;
    logic [HELD_W-1:0]   samples_held;
    logic [STATUS_W-1:0] latest_status;
    logic                sample_taken;
  } gma_out_t;

  typedef struct packed {
    logic                taken;
    logic [STATUS_W-1:0] status;
    logic [RANGE_W-1:0]  range;
  } gma_item_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_UPD  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } gma_state_e;

endpackage

// ----- sv/gma_ram.sv -----
// generic single write port ram with registered read
// no dependencies
module gma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/gma_front.sv -----
// input side: accepts measurements and classifies them for the window
// depends on gma_pkg
module gma_front (
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gma_pkg::gma_in_t   in_data_i,
  input  logic               full_i,
  output logic               push_o,
  output gma_pkg::gma_item_t item_o
);

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;

  always_comb begin
    item_o.status = in_data_i.measure_status;
    item_o.range  = in_data_i.measured_range;
    item_o.taken  = (in_data_i.measure_status == gma_pkg::STATUS_OK) &&
                    (in_data_i.measured_range != '0);
  end

endmodule

// ----- sv/gma_queue.sv -----
// short queue of classified measurements between front and back
// depends on gma_pkg
module gma_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  gma_pkg::gma_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output gma_pkg::gma_item_t item_o
);

  gma_pkg::gma_item_t              entry_q [gma_pkg::QUEUE_DEPTH];
  logic [gma_pkg::QPTR_W-1:0]      wptr_q, wptr_d, rptr_q, rptr_d;
  logic [gma_pkg::QCNT_W-1:0]      cnt_q, cnt_d;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == gma_pkg::QCNT_W'(gma_pkg::QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = entry_q[rptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == gma_pkg::QPTR_W'(gma_pkg::QUEUE_DEPTH - 1)) ? '0
             : wptr_q + gma_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == gma_pkg::QPTR_W'(gma_pkg::QUEUE_DEPTH - 1)) ? '0
             : rptr_q + gma_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + gma_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - gma_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= item_i;
    end
  end

endmodule

// ----- sv/gma_back.sv -----
// back end: window update, serial mean division and result register
// depends on gma_pkg and gma_ram
module gma_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_valid_i,
  input  gma_pkg::gma_item_t          q_item_i,
  output logic                        q_pop_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [gma_pkg::THR_W-1:0]   cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gma_pkg::gma_out_t           out_data_o
);

  localparam int CNT_W  = gma_pkg::CNT_W;
  localparam int SUM_W  = gma_pkg::SUM_W;
  localparam int PTR_W  = gma_pkg::PTR_W;
  localparam int MEAN_W = gma_pkg::MEAN_W;

  gma_pkg::gma_state_e              state_q, state_d;
  gma_pkg::gma_item_t               item_q, item_d;
  logic [PTR_W-1:0]                 ptr_q, ptr_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [SUM_W-1:0]                 sum_q, sum_d;
  logic [MEAN_W-1:0]                mean_q, mean_d;
  logic [CNT_W-1:0]                 rem_q, rem_d;
  logic [MEAN_W-1:0]                shift_q, shift_d;
  logic [gma_pkg::DIV_CNT_W-1:0]    bit_q, bit_d;
  logic [gma_pkg::THR_W-1:0]        thr_q;
  logic                             out_valid_q, out_valid_d;
  gma_pkg::gma_out_t                out_q, out_d;

  logic [gma_pkg::RANGE_W-1:0]      ram_rdata;
  logic                             ram_re, ram_we;
  logic                             full;
  logic [SUM_W-1:0]                 sum_new;
  logic [CNT_W-1:0]                 cnt_new;
  logic [gma_pkg::DIVD_W-1:0]       dividend;
  logic [CNT_W:0]                   trial;
  logic                             qbit;
  logic                             out_free;
  logic [gma_pkg::CMP_W-1:0]        cnt_ext, thr_ext;

  gma_ram #(
    .WIDTH (gma_pkg::RANGE_W),
    .DEPTH (gma_pkg::WINDOW_SIZE)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (item_q.range),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign full        = (cnt_q == CNT_W'(gma_pkg::WINDOW_SIZE));
  assign sum_new     = sum_q - (full ? SUM_W'(ram_rdata) : '0) + SUM_W'(item_q.range);
  assign cnt_new     = full ? cnt_q : cnt_q + CNT_W'(1);
  assign dividend    = {sum_new, {gma_pkg::FRAC_W{1'b0}}};
  assign trial       = {rem_q, shift_q[MEAN_W-1]} - {1'b0, cnt_q};
  assign qbit        = ~trial[CNT_W];
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign cnt_ext     = gma_pkg::CMP_W'(cnt_q);
  assign thr_ext     = gma_pkg::CMP_W'(thr_q);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    ptr_d       = ptr_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    rem_d       = rem_q;
    shift_d     = shift_q;
    bit_d       = bit_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & out_stall_i;
    q_pop_o     = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    case (state_q)
      gma_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          state_d = q_item_i.taken ? gma_pkg::ST_READ : gma_pkg::ST_OUT;
        end
      end
      gma_pkg::ST_READ: begin
        ram_re  = 1'b1;
        state_d = gma_pkg::ST_UPD;
      end
      gma_pkg::ST_UPD: begin
        ram_we  = 1'b1;
        sum_d   = sum_new;
        cnt_d   = cnt_new;
        ptr_d   = (ptr_q == PTR_W'(gma_pkg::WINDOW_SIZE - 1)) ? '0 : ptr_q + PTR_W'(1);
        rem_d   = CNT_W'(dividend[gma_pkg::DIVD_W-1:MEAN_W]);
        shift_d = dividend[MEAN_W-1:0];
        bit_d   = '0;
        state_d = gma_pkg::ST_DIV;
      end
      gma_pkg::ST_DIV: begin
        rem_d   = qbit ? trial[CNT_W-1:0] : rem_q[CNT_W-1:0] << 1 | CNT_W'(shift_q[MEAN_W-1]);
        shift_d = {shift_q[MEAN_W-2:0], qbit};
        bit_d   = bit_q + gma_pkg::DIV_CNT_W'(1);
        if (bit_q == gma_pkg::DIV_CNT_W'(MEAN_W - 1)) begin
          mean_d  = {shift_q[MEAN_W-2:0], qbit};
          state_d = gma_pkg::ST_OUT;
        end
      end
      gma_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.filtered_distance = mean_q;
          out_d.is_ready          = (cnt_ext >= thr_ext);
          out_d.samples_held      = cnt_ext[gma_pkg::HELD_W-1:0];
          out_d.latest_status     = item_q.status;
          out_d.sample_taken      = item_q.taken;
          state_d                 = gma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = gma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gma_pkg::ST_IDLE;
      ptr_q       <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      bit_q       <= '0;
      thr_q       <= gma_pkg::READY_THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      mean_q      <= mean_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q  <= item_d;
    rem_q   <= rem_d;
    shift_q <= shift_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/gated_moving_average.sv -----
// top level of the gated moving average: front, queue and back end
// depends on gma_pkg, gma_front, gma_queue and gma_back
// a rejected measurement goes from the queue straight to the result load; a stored one
// passes ring read, sum update, one-bit-per-cycle serial division and result load
// the back end takes the next queued item only after the result of the last one is loaded
// reset: window emptied, sum and mean cleared, result valid dropped, ready threshold back to 5
module gated_moving_average (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  gma_pkg::gma_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output gma_pkg::gma_out_t         out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gma_pkg::THR_W-1:0] cfg_data_i
);

  logic               q_full, q_push, q_valid, q_pop;
  gma_pkg::gma_item_t front_item, q_item;

  gma_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .full_i     (q_full),
    .push_o     (q_push),
    .item_o     (front_item)
  );

  gma_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (front_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  gma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
